// ----- src/quicksort_engine_assert.svh -----
// assertion macros for the quicksort engine
`ifndef QUICKSORT_ENGINE_ASSERT_SVH
`define QUICKSORT_ENGINE_ASSERT_SVH

// property that must hold at every edge outside reset
`define QS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the following edge
`define QS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/qse_pkg.sv -----
// ----------------------------------------------------------------------------
// qse_pkg
// shared types and constants of the quicksort engine
// ----------------------------------------------------------------------------
package qse_pkg;

    localparam int MAX_KEYS_DEF = 64;
    localparam int KEY_W        = 64;
    localparam int STACK_DEPTH  = 8;

    // commands from controller to datapath
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_WRITE_IN,   // store input key at count
        CMD_RD_MID,     // read store at mid
        CMD_RD_HI,      // read store at hi
        CMD_WR_SWAP_MH, // write hi-key just read at mid
        CMD_RD_J,       // read store at j
        CMD_RD_I,       // read store at i
        CMD_WR_SWAP_IJ, // write i-key just read at j
        CMD_WR_FINAL,   // write i-key just read at hi
        CMD_RD_OUT,     // read store at output index
        CMD_WR_HOLD,    // write held j-key at i
        CMD_WR_PIVOT    // write pivot at i
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic rd_less;   // last read key below pivot
    } t_status;

    // sign-magnitude to unsigned order code
    function automatic logic [KEY_W-1:0] order_code(input logic [KEY_W-1:0] b);
        order_code = b[KEY_W-1] ? ~b : (b | {1'b1, {(KEY_W-1){1'b0}}});
    endfunction

endpackage

// ----- src/qse_ram.sv -----
// ----------------------------------------------------------------------------
// qse_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module qse_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write or read one address per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- src/qse_datapath.sv -----
// ----------------------------------------------------------------------------
// qse_datapath
// key store, pivot and swap holding registers, comparator
// ----------------------------------------------------------------------------
module qse_datapath #(
    parameter int MAX_KEYS = qse_pkg::MAX_KEYS_DEF
) (
    input  logic                        i_clk,
    input  qse_pkg::t_cmd               i_cmd,
    input  logic [$clog2(MAX_KEYS)-1:0] i_addr,
    input  logic [qse_pkg::KEY_W-1:0]   i_key,
    output qse_pkg::t_status            o_status,
    output logic [qse_pkg::KEY_W-1:0]   o_rdata
);
    localparam int AW = $clog2(MAX_KEYS);

    logic                      we;
    logic [qse_pkg::KEY_W-1:0] wdata;
    logic [qse_pkg::KEY_W-1:0] rdata;
    logic [qse_pkg::KEY_W-1:0] r_pivot;
    logic [qse_pkg::KEY_W-1:0] r_hold;
    qse_pkg::t_cmd             r_last_cmd;
    logic [AW-1:0]             addr;

    assign addr = i_addr;

    // write data selection: input key, key just read, held key or pivot
    always_comb begin
        we    = 1'b0;
        wdata = r_hold;
        unique case (i_cmd) inside
            qse_pkg::CMD_WRITE_IN: begin
                we    = 1'b1;
                wdata = i_key;
            end
            qse_pkg::CMD_WR_SWAP_MH, qse_pkg::CMD_WR_SWAP_IJ, qse_pkg::CMD_WR_FINAL: begin
                we    = 1'b1;
                wdata = rdata;
            end
            qse_pkg::CMD_WR_HOLD: begin
                we    = 1'b1;
                wdata = r_hold;
            end
            qse_pkg::CMD_WR_PIVOT: begin
                we    = 1'b1;
                wdata = r_pivot;
            end
            default: begin
                we    = 1'b0;
                wdata = r_hold;
            end
        endcase
    end

    qse_ram #(.WIDTH(qse_pkg::KEY_W), .DEPTH(MAX_KEYS)) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    // capture read data from the store's registered output, keyed by the registered read command
    always_ff @(posedge i_clk) begin
        r_last_cmd <= i_cmd;
        if (r_last_cmd == qse_pkg::CMD_RD_MID) begin
            r_pivot <= rdata;
        end
        if (r_last_cmd == qse_pkg::CMD_RD_J) begin
            r_hold <= rdata;
        end
    end

    assign o_status.rd_less = qse_pkg::order_code(rdata) < qse_pkg::order_code(r_pivot);
    assign o_rdata          = rdata;
endmodule

// ----- src/qse_ctrl.sv -----
// ----------------------------------------------------------------------------
// qse_ctrl
// controller: loading, partition sequencing, range stack and readout
// ----------------------------------------------------------------------------
module qse_ctrl #(
    parameter int MAX_KEYS = qse_pkg::MAX_KEYS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_in_last,
    input  logic                        i_out_slot_free,
    input  qse_pkg::t_status            i_status,
    output qse_pkg::t_cmd               o_cmd,
    output logic [$clog2(MAX_KEYS)-1:0] o_addr,
    output logic                        o_rd_out,
    output logic                        o_rd_last
);
    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int SW = $clog2(qse_pkg::STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_LOAD, S_POP, S_RD_MID, S_RD_HI, S_SWAP_MH, S_RD_J, S_CMP,
        S_RD_I, S_SWAP_IJ, S_RD_IF, S_FINAL, S_OUT, S_WR_HOLD, S_WR_PIV
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_lo, n_lo, r_hi, n_hi, r_i, n_i, r_j, n_j, r_mid, n_mid;
    logic [2*AW-1:0] r_stack [qse_pkg::STACK_DEPTH];
    logic [SW-1:0]   r_sp, n_sp;
    logic [CW-1:0]   r_oidx, n_oidx;
    logic            push_a, push_b;
    logic [2*AW-1:0] push_a_val, push_b_val;
    logic [AW:0]     left_n, right_n;
    logic [2*AW-1:0] top;
    logic [AW:0]     span;

    assign o_in_ready   = (r_state == S_LOAD);
    assign top          = r_stack[r_sp[$clog2(qse_pkg::STACK_DEPTH)-1:0] - 1'b1];
    assign left_n       = {1'b0, r_i} - {1'b0, r_lo};
    assign right_n      = {1'b0, r_hi} - {1'b0, r_i};
    assign span         = {1'b0, top[AW-1:0]} - {1'b0, top[2*AW-1:AW]} + 1'b1;

    // next state and command
    always_comb begin
        n_state = r_state; n_count = r_count; n_lo = r_lo; n_hi = r_hi;
        n_i = r_i; n_j = r_j; n_mid = r_mid; n_sp = r_sp; n_oidx = r_oidx;
        o_cmd = qse_pkg::CMD_NONE; o_addr = r_j; o_rd_out = 1'b0; o_rd_last = 1'b0;
        push_a = 1'b0; push_b = 1'b0;
        push_a_val = {r_lo, r_i - 1'b1}; push_b_val = {r_i + 1'b1, r_hi};
        unique case (r_state)
            S_LOAD: begin
                o_addr = r_count[AW-1:0];
                if (i_in_valid) begin
                    o_cmd   = qse_pkg::CMD_WRITE_IN;
                    n_count = r_count + 1'b1;
                    if (i_in_last || r_count == CW'(MAX_KEYS - 1)) begin
                        n_oidx = '0;
                        if (r_count == '0) begin
                            n_state = S_OUT;
                        end else begin
                            n_lo = '0; n_hi = r_count[AW-1:0];
                            n_state = S_RD_MID;
                            n_mid = AW'(({1'b0, r_count[AW-1:0]} + 1'b1) >> 1);
                        end
                    end
                end
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_state = S_OUT; n_oidx = '0;
                end else begin
                    n_sp = r_sp - 1'b1;
                    n_lo = top[2*AW-1:AW]; n_hi = top[AW-1:0];
                    n_mid = AW'({1'b0, top[2*AW-1:AW]} + (span >> 1));
                    n_state = S_RD_MID;
                end
            end
            S_RD_MID: begin
                o_cmd = qse_pkg::CMD_RD_MID; o_addr = r_mid; n_state = S_RD_HI;
            end
            S_RD_HI: begin
                o_cmd = qse_pkg::CMD_RD_HI; o_addr = r_hi; n_state = S_SWAP_MH;
            end
            S_SWAP_MH: begin
                // hi-key arriving from the store goes to mid; pivot stays in its register
                o_cmd = qse_pkg::CMD_WR_SWAP_MH; o_addr = r_mid;
                n_i = r_lo; n_j = r_lo; n_state = S_RD_J;
            end
            S_RD_J: begin
                if (r_j == r_hi) begin
                    n_state = S_RD_IF;
                end else begin
                    o_cmd = qse_pkg::CMD_RD_J; o_addr = r_j; n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_status.rd_less) begin
                    n_state = S_RD_I;
                end else begin
                    n_j = r_j + 1'b1; n_state = S_RD_J;
                end
            end
            S_RD_I: begin
                o_cmd = qse_pkg::CMD_RD_I; o_addr = r_i; n_state = S_SWAP_IJ;
            end
            S_SWAP_IJ: begin
                // i-key arriving from the store goes to j; hold keeps the j-key
                o_cmd = qse_pkg::CMD_WR_SWAP_IJ; o_addr = r_j;
                n_state = S_WR_HOLD;
            end
            S_WR_HOLD: begin
                o_cmd = qse_pkg::CMD_WR_HOLD; o_addr = r_i;
                n_i = r_i + 1'b1; n_j = r_j + 1'b1; n_state = S_RD_J;
            end
            S_RD_IF: begin
                o_cmd = qse_pkg::CMD_RD_I; o_addr = r_i; n_state = S_FINAL;
            end
            S_FINAL: begin
                // i-key goes to hi, pivot to i next
                o_cmd = qse_pkg::CMD_WR_FINAL; o_addr = r_hi; n_state = S_WR_PIV;
            end
            S_WR_PIV: begin
                o_cmd = qse_pkg::CMD_WR_PIVOT; o_addr = r_i;
                n_state = S_POP;
                // larger part pushed first so the smaller is taken next
                if (left_n >= right_n) begin
                    push_a = (left_n >= 2); push_b = (right_n >= 2);
                    push_a_val = {r_lo, r_i - 1'b1}; push_b_val = {r_i + 1'b1, r_hi};
                end else begin
                    push_a = (right_n >= 2); push_b = (left_n >= 2);
                    push_a_val = {r_i + 1'b1, r_hi}; push_b_val = {r_lo, r_i - 1'b1};
                end
            end
            S_OUT: begin
                o_addr = r_oidx[AW-1:0];
                if (r_oidx == r_count) begin
                    n_state = S_LOAD; n_count = '0;
                end else if (i_out_slot_free) begin
                    o_cmd = qse_pkg::CMD_RD_OUT; o_rd_out = 1'b1;
                    o_rd_last = (r_oidx + 1'b1 == r_count);
                    n_oidx = r_oidx + 1'b1;
                end
            end
            default: n_state = S_LOAD;
        endcase
        if (push_a && push_b) n_sp = r_sp + 2'd2;
        else if (push_a || push_b) n_sp = r_sp + 1'b1;
    end

    // state, counters and range stack
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD; r_count <= '0; r_sp <= '0; r_oidx <= '0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_sp <= n_sp; r_oidx <= n_oidx;
        end
        r_lo <= n_lo; r_hi <= n_hi; r_i <= n_i; r_j <= n_j; r_mid <= n_mid;
        if (push_a) r_stack[r_sp[$clog2(qse_pkg::STACK_DEPTH)-1:0]] <= push_a_val;
        if (push_b) r_stack[r_sp[$clog2(qse_pkg::STACK_DEPTH)-1:0] + 1'b1] <= push_b_val;
    end
endmodule

// ----- src/quicksort_engine.sv -----
// ----------------------------------------------------------------------------
// quicksort_engine
// collects a set of double keys, sorts them ascending by quicksort, streams them out
// ----------------------------------------------------------------------------
// Keys load at one per cycle until tlast or a full store of MAX_KEYS keys;
// the set is then sorted in place in a single-port key memory. Each partition
// pass reads the mid key as pivot and the hi key, writes the hi key at mid,
// compares each key from lo to below hi with the pivot and swaps one below it
// with the key at i; the key at i then goes to hi, the pivot to i, and the
// next range is popped (N log N compare steps on average). Sorted keys are read
// out one at a time once the previous key is registered and the output slot
// is free, the final key with tlast. No input is taken while a set is sorted
// or emitted. Keys order by their sign-magnitude bits, so -0 precedes +0.
module quicksort_engine #(
    parameter int MAX_KEYS = qse_pkg::MAX_KEYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // key_bits
    input  logic        s_axis_tlast,  // final_key
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // sorted_bits
    output logic        m_axis_tlast   // end_of_run
);
    `include "quicksort_engine_assert.svh"

    localparam int AW = $clog2(MAX_KEYS);

    qse_pkg::t_cmd    cmd;
    qse_pkg::t_status status;
    logic [AW-1:0]    addr;
    logic             rd_out, rd_last;
    logic [63:0]      rdata;
    logic             r_rd_pend, r_rd_last;
    logic             slot_free;
    logic             out_stall;
    logic [65:0]      out_word;

    assign slot_free = !m_axis_tvalid || m_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_word  = {m_axis_tvalid, m_axis_tlast, m_axis_tdata};

    qse_ctrl #(.MAX_KEYS(MAX_KEYS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_in_last(s_axis_tlast), .i_out_slot_free(slot_free && !r_rd_pend),
        .i_status(status), .o_cmd(cmd), .o_addr(addr),
        .o_rd_out(rd_out), .o_rd_last(rd_last)
    );

    qse_datapath #(.MAX_KEYS(MAX_KEYS)) u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_addr(addr),
        .i_key(s_axis_tdata), .o_status(status),
        .o_rdata(rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0; m_axis_tvalid <= 1'b0;
        end else begin
            r_rd_pend <= rd_out;
            if (r_rd_pend) m_axis_tvalid <= 1'b1;
            else if (m_axis_tready) m_axis_tvalid <= 1'b0;
        end
        r_rd_last <= rd_last;
        if (r_rd_pend) begin
            m_axis_tdata <= rdata; m_axis_tlast <= r_rd_last;
        end
    end

    `QS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, $stable(out_word), "output moved")
    `QS_ASSERT_NEXT(a_rd_lands, i_clk, i_rst_n, rd_out, m_axis_tvalid || r_rd_pend, "readout lost")
endmodule
